/* rtl/core/assert_macros.svh */
// Assertion helpers, sampled on clk_i, disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/core/sgr_pkg.sv */
package sgr_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned DIV_STEPS   = 64;
  localparam int unsigned ROOT_STEPS  = 32;
  localparam int unsigned PIPE_STEPS  = DIV_STEPS + ROOT_STEPS;
  localparam logic [31:0] ONE_Q30     = 32'h4000_0000;

  typedef struct packed {
    logic        a_neg;
    logic        b_neg;
    logic        zero;
    logic [31:0] a_mag;
    logic [31:0] b_mag;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage

/* rtl/core/sgr_front.sv */
module sgr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [63:0]        in_data_i,
  input  sgr_pkg::q_stat_t   q_stat_i,
  output sgr_pkg::push_t     push_o
);

  logic          valid_q, valid_d;
  sgr_pkg::item_t item_q, item_d;
  logic [31:0]   a_v, b_v;

  assign a_v = in_data_i[31:0];
  assign b_v = in_data_i[63:32];

  assign in_ready_o = !valid_q || !q_stat_i.full;

  always_comb begin
    item_d.a_neg = a_v[31];
    item_d.b_neg = b_v[31];
    item_d.a_mag = a_v[31] ? (32'd0 - a_v) : a_v;
    item_d.b_mag = b_v[31] ? (32'd0 - b_v) : b_v;
    item_d.zero  = (a_v == 32'd0) && (b_v == 32'd0);
  end

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

  assign push_o.valid = valid_q && !q_stat_i.full;
  assign push_o.item  = item_q;

endmodule

/* rtl/core/sgr_queue.sv */
module sgr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sgr_pkg::push_t   push_i,
  input  logic             pop_i,
  output sgr_pkg::item_t   head_o,
  output sgr_pkg::q_stat_t stat_o
);

  sgr_pkg::item_t                  mem_q [sgr_pkg::QUEUE_DEPTH];
  logic [sgr_pkg::QPTR_W-1:0]      wptr_q, wptr_d, rptr_q, rptr_d;
  logic [sgr_pkg::QCNT_W-1:0]      cnt_q, cnt_d;
  logic                            do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i.valid) begin
      wptr_d = (wptr_q == sgr_pkg::QPTR_W'(sgr_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == sgr_pkg::QPTR_W'(sgr_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i.valid && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i.valid && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wptr_q] <= push_i.item;
    end
  end

  assign head_o       = mem_q[rptr_q];
  assign stat_o.count = cnt_q;
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == sgr_pkg::QCNT_W'(sgr_pkg::QUEUE_DEPTH));

endmodule

/* rtl/core/sgr_back.sv */
module sgr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sgr_pkg::item_t   head_i,
  input  logic             q_empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [95:0]      out_data_o
);

  typedef struct packed {
    logic        a_neg;
    logic        b_neg;
    logic        zero;
    logic [63:0] n;
    logic [63:0] crem;
    logic [63:0] cquo;
    logic [63:0] cres;
    logic [3:0]  clo;
    logic [63:0] srem;
    logic [63:0] squo;
    logic [63:0] sres;
    logic [3:0]  slo;
    logic [63:0] lrem;
    logic [63:0] lres;
  } stg_t;

  typedef struct packed {
    logic        a_neg;
    logic        b_neg;
    logic        zero;
    logic [63:0] sqa;
    logic [63:0] sqb;
  } mul_t;

  localparam int unsigned NST = sgr_pkg::PIPE_STEPS;

  function automatic stg_t step_f(stg_t s, int k);
    stg_t        r;
    logic [63:0] rem2;
    logic [63:0] bitv;
    logic [63:0] tr;
    int          j;
    r = s;
    j = k - sgr_pkg::DIV_STEPS;
    if (k < sgr_pkg::DIV_STEPS) begin
      rem2  = {s.crem[62:0], s.clo[3]};
      r.clo = {s.clo[2:0], 1'b0};
      if (rem2 >= s.n) begin
        r.crem = rem2 - s.n;
        r.cquo = {s.cquo[62:0], 1'b1};
      end else begin
        r.crem = rem2;
        r.cquo = {s.cquo[62:0], 1'b0};
      end
      rem2  = {s.srem[62:0], s.slo[3]};
      r.slo = {s.slo[2:0], 1'b0};
      if (rem2 >= s.n) begin
        r.srem = rem2 - s.n;
        r.squo = {s.squo[62:0], 1'b1};
      end else begin
        r.srem = rem2;
        r.squo = {s.squo[62:0], 1'b0};
      end
      if (k < sgr_pkg::ROOT_STEPS) begin
        bitv = 64'd1 << (62 - 2 * k);
        tr   = s.lres + bitv;
        if (s.lrem >= tr) begin
          r.lrem = s.lrem - tr;
          r.lres = (s.lres >> 1) + bitv;
        end else begin
          r.lres = s.lres >> 1;
        end
      end
    end else begin
      bitv = 64'd1 << (62 - 2 * j);
      tr   = s.cres + bitv;
      if (s.cquo >= tr) begin
        r.cquo = s.cquo - tr;
        r.cres = (s.cres >> 1) + bitv;
      end else begin
        r.cres = s.cres >> 1;
      end
      tr = s.sres + bitv;
      if (s.squo >= tr) begin
        r.squo = s.squo - tr;
        r.sres = (s.sres >> 1) + bitv;
      end else begin
        r.sres = s.sres >> 1;
      end
    end
    return r;
  endfunction

  logic        adv;
  logic        mv_q;
  mul_t        mul_q;
  logic        vld_q [NST+1];
  stg_t        pipe_q [NST+1];
  stg_t        pipe_d [NST+1];
  logic        ov_q;
  logic [95:0] od_q, od_d;
  stg_t        fin;
  logic [63:0] thr;
  logic        cup, sup, lup;
  logic [31:0] cm, sm, lm;

  assign adv   = !ov_q || out_ready_i;
  assign pop_o = adv && !q_empty_i;

  always_comb begin
    pipe_d[0].a_neg = mul_q.a_neg;
    pipe_d[0].b_neg = mul_q.b_neg;
    pipe_d[0].zero  = mul_q.zero;
    pipe_d[0].n     = mul_q.sqa + mul_q.sqb;
    pipe_d[0].crem  = mul_q.sqa >> 4;
    pipe_d[0].clo   = mul_q.sqa[3:0];
    pipe_d[0].cquo  = '0;
    pipe_d[0].cres  = '0;
    pipe_d[0].srem  = mul_q.sqb >> 4;
    pipe_d[0].slo   = mul_q.sqb[3:0];
    pipe_d[0].squo  = '0;
    pipe_d[0].sres  = '0;
    pipe_d[0].lrem  = mul_q.sqa + mul_q.sqb;
    pipe_d[0].lres  = '0;
    for (int k = 0; k < NST; k++) begin
      pipe_d[k+1] = step_f(pipe_q[k], k);
    end
  end

  always_comb begin
    fin = pipe_q[NST];
    thr = (fin.n + 64'd3) >> 2;
    cup = (fin.cquo > fin.cres) || ((fin.cquo == fin.cres) && (fin.crem >= thr));
    sup = (fin.squo > fin.sres) || ((fin.squo == fin.sres) && (fin.srem >= thr));
    lup = fin.lrem > fin.lres;
    cm  = fin.cres[31:0] + {31'd0, cup};
    sm  = fin.sres[31:0] + {31'd0, sup};
    lm  = fin.lres[31:0] + {31'd0, lup};
    if (fin.zero) begin
      od_d = {32'd0, 32'd0, sgr_pkg::ONE_Q30};
    end else begin
      od_d = {lm, (fin.b_neg ? (32'd0 - sm) : sm), (fin.a_neg ? (32'd0 - cm) : cm)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
      ov_q <= 1'b0;
      for (int k = 0; k <= NST; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (adv) begin
      mv_q     <= !q_empty_i;
      vld_q[0] <= mv_q;
      for (int k = 0; k < NST; k++) begin
        vld_q[k+1] <= vld_q[k];
      end
      ov_q <= vld_q[NST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mul_q.a_neg <= head_i.a_neg;
      mul_q.b_neg <= head_i.b_neg;
      mul_q.zero  <= head_i.zero;
      mul_q.sqa   <= head_i.a_mag * head_i.a_mag;
      mul_q.sqb   <= head_i.b_mag * head_i.b_mag;
      for (int k = 0; k <= NST; k++) begin
        pipe_q[k] <= pipe_d[k];
      end
      od_q <= od_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

endmodule

/* rtl/core/symmetric_givens_rotation.sv */
// Throughput: one pair per cycle unless the output stalls; the 96-step
// divide and root pipeline advances whenever the output register is empty
// or being taken.
// A four-entry queue separates the input classifier from the arithmetic pipeline.
// Reset (rst_ni low, asynchronous) clears all valid flags and queue pointers.
`include "assert_macros.svh"

module symmetric_givens_rotation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // a_value[31:0], b_value[63:32]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [95:0] m_axis_tdata_o   // cosine[31:0], sine[63:32], length[95:64]
);

  sgr_pkg::push_t   push;
  sgr_pkg::q_stat_t q_stat;
  sgr_pkg::item_t   head;
  logic             pop;

  sgr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_data_i  (s_axis_tdata_i),
    .q_stat_i   (q_stat),
    .push_o     (push)
  );

  sgr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  sgr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_empty_i   (q_stat.empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

  `ASSERT_CLK(a_no_push_full, !(push.valid && q_stat.full), "push into full queue")
  `ASSERT_CLK(a_cnt_range, q_stat.count <= sgr_pkg::QCNT_W'(sgr_pkg::QUEUE_DEPTH), "queue count overflow")
  `ASSERT_NEXT(a_cnt_step, push.valid && !pop, q_stat.count == $past(q_stat.count) + 1'b1, "queue count not incremented")

endmodule

/* tb/symmetric_givens_rotation_test.sv */
`timescale 1ns / 1ps

module symmetric_givens_rotation_test;

  typedef struct packed {
    logic [31:0] cosine;
    logic [31:0] sine;
    logic [31:0] length;
  } rotation_t;

  class rotation_board;
    rotation_t pending[$];
    int unsigned errors;
    int unsigned checked;

    function logic [63:0] isqrt(logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function logic [63:0] unit_ratio(logic [63:0] mag, logic [63:0] n);
      logic [127:0] num;
      logic [127:0] quo;
      logic [127:0] rem;
      logic [63:0] q;
      logic [63:0] t;
      num = {64'd0, mag * mag} << 60;
      quo = num / n;
      rem = num % n;
      q = isqrt(quo[63:0]);
      t = q * q + q;
      if (quo[63:0] > t || (quo[63:0] == t && rem[63:0] >= (n + 3) / 4)) q += 1;
      return q;
    endfunction

    function void note_pair(logic [31:0] a, logic [31:0] b);
      logic [63:0] am;
      logic [63:0] bm;
      logic [63:0] n;
      logic [63:0] len;
      logic [63:0] cm;
      logic [63:0] sm;
      rotation_t r;
      am = a[31] ? (64'd1 << 32) - {32'd0, a} : {32'd0, a};
      bm = b[31] ? (64'd1 << 32) - {32'd0, b} : {32'd0, b};
      n = am * am + bm * bm;
      if (n == 0) begin
        r.cosine = 32'h4000_0000;
        r.sine = 0;
        r.length = 0;
      end else begin
        len = isqrt(n);
        if (n - len * len > len) len += 1;
        cm = unit_ratio(am, n);
        sm = unit_ratio(bm, n);
        r.cosine = a[31] ? 32'd0 - cm[31:0] : cm[31:0];
        r.sine = b[31] ? 32'd0 - sm[31:0] : sm[31:0];
        r.length = len[31:0];
      end
      pending.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("%s", msg);
    endtask

    task check_result(logic [95:0] data);
      rotation_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h", data));
        return;
      end
      exp_r = pending.pop_front();
      if (data[31:0] !== exp_r.cosine) begin
        report($sformatf("cosine got %h exp %h", data[31:0], exp_r.cosine));
      end
      if (data[63:32] !== exp_r.sine) begin
        report($sformatf("sine got %h exp %h", data[63:32], exp_r.sine));
      end
      if (data[95:64] !== exp_r.length) begin
        report($sformatf("length got %h exp %h", data[95:64], exp_r.length));
      end
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid_i = 0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = 0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 0;
  logic [95:0] m_axis_tdata_o;

  rotation_board board = new();
  int unsigned sent;
  bit          stim_done;
  bit          hold_sink;

  symmetric_givens_rotation u_dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  task automatic send_pair(logic [31:0] a, logic [31:0] b);
    int gap;
    gap = (($urandom % 4) == 0) ? 0 : $urandom_range(0, 13);
    if ($urandom % 3 == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tdata_i <= {b, a};
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_pair(a, b);
    sent++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom % 8)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 0;
      3: return $urandom_range(0, 255) - 128;
      4: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] corner[8];
    corner = '{32'h0, 32'h1, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
               32'h0001_0000, 32'hffff_0000, 32'h0000_8000};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    foreach (corner[i]) send_pair(corner[i], 0);
    foreach (corner[i]) send_pair(0, corner[i]);
    send_pair(32'h8000_0000, 32'h8000_0000);
    send_pair(32'h7fff_ffff, 32'h7fff_ffff);
    send_pair(32'h0003_0000, 32'hfffc_0000);
    send_pair(32'hffff_ffff, 32'h0000_0001);
    send_pair(32'haaaa_aaaa, 32'h5555_5555);
    send_pair(32'h5555_5555, 32'haaaa_aaaa);
    repeat (1430) send_pair(pick_value(), pick_value());
    s_axis_tvalid_i <= 0;
    stim_done = 1;
  end

  initial begin
    int wait_cycles;
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        m_axis_tready_i <= 0;
      end else begin
        wait_cycles = ($urandom % 3 == 0) ? 0 : $urandom_range(0, 13);
        if (wait_cycles == 0) begin
          m_axis_tready_i <= 1;
        end else begin
          m_axis_tready_i <= 0;
          repeat (wait_cycles) @(posedge clk_i);
          m_axis_tready_i <= 1;
        end
      end
    end
  end

  initial begin
    wait (sent == 300);
    hold_sink = 1;
    repeat (400) @(posedge clk_i);
    hold_sink = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) board.check_result(m_axis_tdata_o);
  end

  initial begin
    wait (stim_done);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    $display("Sent %0d pairs with zero, sign and full-scale corners; %0d results checked.",
             sent, board.checked);
    if (board.errors == 0) begin
      $display("PASS symmetric_givens_rotation");
    end else begin
      $display("FAIL symmetric_givens_rotation");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL symmetric_givens_rotation");
    $finish;
  end

endmodule
